// File: rtl/core/tomqm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tomqm_pkg
// Shared sizes, codes and control structs of the time-ordered queue merge.
// ----------------------------------------------------------------------------
package tomqm_pkg;

  localparam int NUM_QUEUES = 4;
  localparam int FIFO_DEPTH = 8;   // power of two: ring index wraps by truncation
  localparam int TIME_BITS  = 48;
  localparam int DATA_BITS  = 32;

  localparam int QW        = $clog2(NUM_QUEUES);
  localparam int PW        = $clog2(FIFO_DEPTH);
  localparam int SLOTS     = NUM_QUEUES * FIFO_DEPTH;
  localparam int AW        = $clog2(SLOTS);
  localparam int WORD_BITS = TIME_BITS + DATA_BITS;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_FINISH = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  localparam logic KIND_ITEM   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Update request for the selected queue (push/pop/finish/retire) or all (flush)
  typedef struct packed {
    logic push;
    logic pop;
    logic finish;
    logic flush;
    logic retire;
  } qcmd_t;

  // Bookkeeping of the selected queue
  typedef struct packed {
    logic          live;
    logic          finished;
    logic [PW-1:0] head;
    logic [PW:0]   fill;
    logic          all_done;
  } qstat_t;

endpackage

// File: rtl/core/tomqm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tomqm_in_if / tomqm_out_if
// Valid/ready channels carrying input words and result words.
// ----------------------------------------------------------------------------
interface tomqm_in_if;
  import tomqm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           operation;
  logic [1:0]           queue_id;
  logic [TIME_BITS-1:0] timestamp;
  logic [DATA_BITS-1:0] payload;

  modport source (output valid, operation, queue_id, timestamp, payload, input ready);
  modport sink   (input valid, operation, queue_id, timestamp, payload, output ready);
endinterface

interface tomqm_out_if;
  import tomqm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [1:0]           source_queue;
  logic [TIME_BITS-1:0] item_time;
  logic [DATA_BITS-1:0] item_data;
  logic                 order_error;
  logic                 input_dropped;
  logic                 blocked;
  logic [1:0]           blocker_queue;
  logic                 all_done;
  logic                 last;

  modport source (output valid, kind, source_queue, item_time, item_data, order_error,
                  input_dropped, blocked, blocker_queue, all_done, last, input ready);
  modport sink   (input valid, kind, source_queue, item_time, item_data, order_error,
                  input_dropped, blocked, blocker_queue, all_done, last, output ready);
endinterface

// File: rtl/core/tomqm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tomqm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tomqm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/tomqm_qstate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tomqm_qstate
// Per-queue ring pointers, fill counts, finished/retired flags and queue mask.
// ----------------------------------------------------------------------------
module tomqm_qstate (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tomqm_pkg::NUM_QUEUES-1:0]    cfg_mask,
  input  logic [tomqm_pkg::QW-1:0]            sel_q,
  input  tomqm_pkg::qcmd_t                    cmd,
  output tomqm_pkg::qstat_t                   stat
);
  import tomqm_pkg::*;

  logic [NUM_QUEUES-1:0] mask;
  logic [NUM_QUEUES-1:0] finished;
  logic [NUM_QUEUES-1:0] retired;
  logic [PW-1:0]         head [NUM_QUEUES];
  logic [PW:0]           fill [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] live;
  logic [NUM_QUEUES-1:0] changed;

  assign live    = mask & ~retired;
  assign changed = cfg_mask ^ mask;

  always_comb begin
    stat.live     = live[sel_q];
    stat.finished = finished[sel_q];
    stat.head     = head[sel_q];
    stat.fill     = fill[sel_q];
    stat.all_done = (live == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask     <= '0;
      finished <= '0;
      retired  <= '0;
      for (int q = 0; q < NUM_QUEUES; q++) begin
        head[q] <= '0;
        fill[q] <= '0;
      end
    end else if (cfg_we) begin
      // a slot whose mask bit flips starts over
      mask <= cfg_mask;
      for (int q = 0; q < NUM_QUEUES; q++) begin
        if (changed[q]) begin
          head[q]     <= '0;
          fill[q]     <= '0;
          finished[q] <= 1'b0;
          retired[q]  <= 1'b0;
        end
      end
    end else begin
      if (cmd.push) begin
        fill[sel_q] <= fill[sel_q] + (PW+1)'(1);
      end
      if (cmd.pop) begin
        head[sel_q] <= head[sel_q] + PW'(1);
        fill[sel_q] <= fill[sel_q] - (PW+1)'(1);
      end
      if (cmd.finish && live[sel_q]) begin
        finished[sel_q] <= 1'b1;
      end
      if (cmd.flush) begin
        finished <= finished | live;
      end
      if (cmd.retire) begin
        retired[sel_q] <= 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/timestamp_ordered_multi_queue_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamp_ordered_multi_queue_merge
// K-way merge of per-sensor timestamped FIFOs into one time-ordered stream.
// ----------------------------------------------------------------------------
// Each input word pushes an item into one queue, finishes one queue or
// flushes all of them; the block then dispatches head items oldest first
// (lowest queue index wins a tie) until a registered, unretired queue that
// is empty and not finished blocks the merge, or nothing is left, and closes
// with one status word (last = 1). A finished queue found empty is retired.
// Item words sit in one 80-bit buffer RAM (time and data, NUM_QUEUES x
// FIFO_DEPTH ring entries); pointers, fill counts and flags sit in small
// registers. Each input word is taken and applied, then one scan pass
// runs per dispatched item plus one final pass. A pass visits queues in
// index order, skipping or stopping at a queue or reading its head, which
// the registered RAM read port returns for the compare in S_CMP; S_EMIT
// then emits the word and can stall on the output. The single RAM read
// port is the limit. The next input word is taken right after the status
// word is loaded, while that word may still wait at the output. The user
// must write the queue mask through cfg_we/cfg_wdata only while the block
// is idle; the block does not enforce it. Changed slots reopen empty.
// ----------------------------------------------------------------------------
module timestamp_ordered_multi_queue_merge (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  tomqm_in_if.sink    item_in,
  tomqm_out_if.source item_out
);
  import tomqm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,   // waiting for an input word
    S_APPLY = 5'b00010,   // push / finish / flush
    S_RD    = 5'b00100,   // look at queue scan_q, read its head
    S_CMP   = 5'b01000,   // compare head time against best so far
    S_EMIT  = 5'b10000    // send a dispatched item or the status word
  } state_t;

  state_t state;

  // latched input word
  op_t                  op;
  logic [1:0]           qid;
  logic [TIME_BITS-1:0] ts;
  logic [DATA_BITS-1:0] pl;

  // scan state
  logic [QW-1:0]        scan_q;
  logic                 found;
  logic                 blocked;
  logic                 dropped;
  logic [QW-1:0]        best;
  logic [TIME_BITS-1:0] best_time;
  logic [DATA_BITS-1:0] best_data;
  logic [TIME_BITS-1:0] last_time;
  logic [QW-1:0]        blocker;

  // output register
  logic                 out_valid;
  logic                 o_kind;
  logic [1:0]           o_src;
  logic [TIME_BITS-1:0] o_time;
  logic [DATA_BITS-1:0] o_data;
  logic                 o_oerr;
  logic                 o_drop;
  logic                 o_blk;
  logic [1:0]           o_bq;
  logic                 o_done;
  logic                 o_last;

  // queue bookkeeping
  logic [QW-1:0] sel_q;
  qcmd_t         cmd;
  qstat_t        stat;

  // buffer RAM
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [TIME_BITS-1:0] rd_time;
  logic [DATA_BITS-1:0] rd_data;

  logic qid_ok;
  logic push_ok;
  logic rd_empty;
  logic last_q;
  logic out_free;
  logic out_load;
  logic emit_item;

  tomqm_qstate u_qstate (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_mask (cfg_wdata[NUM_QUEUES-1:0]),
    .sel_q    (sel_q),
    .cmd      (cmd),
    .stat     (stat)
  );

  tomqm_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (SLOTS)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // One queue is looked at per cycle: the input's queue while applying,
  // the winner while emitting, the scanned queue otherwise.
  always_comb begin
    case (state)
      S_APPLY: sel_q = QW'(qid);
      S_EMIT:  sel_q = best;
      default: sel_q = scan_q;
    endcase
  end

  assign qid_ok    = (int'(qid) < NUM_QUEUES);
  assign push_ok   = qid_ok && stat.live && !stat.finished &&
                     (stat.fill < (PW+1)'(FIFO_DEPTH));
  assign rd_empty  = (stat.fill == '0);
  assign last_q    = (scan_q == QW'(NUM_QUEUES - 1));
  assign out_free  = !out_valid || item_out.ready;
  assign out_load  = (state == S_EMIT) && out_free;
  assign emit_item = found && !blocked;

  // Push writes at the ring tail; RAM writes only happen in S_APPLY and
  // reads only during the scan, so the two never touch one entry at once.
  assign ram_we    = (state == S_APPLY) && (op == OP_PUSH) && push_ok;
  assign ram_waddr = {QW'(qid), PW'(stat.head + stat.fill[PW-1:0])};
  assign ram_wdata = {ts, pl};
  assign ram_raddr = {scan_q, stat.head};
  assign rd_time   = ram_rdata[WORD_BITS-1:DATA_BITS];
  assign rd_data   = ram_rdata[DATA_BITS-1:0];

  always_comb begin
    cmd        = '0;
    cmd.push   = ram_we;
    cmd.finish = (state == S_APPLY) && (op == OP_FINISH) && qid_ok;
    cmd.flush  = (state == S_APPLY) && (op == OP_FLUSH);
    cmd.retire = (state == S_RD) && stat.live && rd_empty && stat.finished;
    cmd.pop    = (state == S_EMIT) && out_free && emit_item;
  end

  assign item_in.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      last_time <= '0;
      blocker   <= '0;
      found     <= 1'b0;
      blocked   <= 1'b0;
      dropped   <= 1'b0;
      scan_q    <= '0;
    end else begin
      // a new word loads as the old one leaves
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (item_out.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_in.valid) begin
            op    <= op_t'(item_in.operation);
            qid   <= item_in.queue_id;
            ts    <= item_in.timestamp;
            pl    <= item_in.payload;
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          dropped <= (op == OP_PUSH) && !push_ok;
          blocked <= 1'b0;
          found   <= 1'b0;
          scan_q  <= '0;
          state   <= S_RD;
        end
        S_RD: begin
          if (stat.live && rd_empty && !stat.finished) begin
            // unfinished empty queue: merge must wait for it
            blocker <= scan_q;
            blocked <= 1'b1;
            state   <= S_EMIT;
          end else if (stat.live && !rd_empty) begin
            state <= S_CMP;
          end else if (last_q) begin
            state <= S_EMIT;
          end else begin
            scan_q <= scan_q + QW'(1);
          end
        end
        S_CMP: begin
          // strict compare keeps the lower index on equal times
          if (!found || (rd_time < best_time)) begin
            found     <= 1'b1;
            best      <= scan_q;
            best_time <= rd_time;
            best_data <= rd_data;
          end
          if (last_q) begin
            state <= S_EMIT;
          end else begin
            scan_q <= scan_q + QW'(1);
            state  <= S_RD;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (emit_item) begin
              o_kind    <= KIND_ITEM;
              o_src     <= 2'(best);
              o_time    <= best_time;
              o_data    <= best_data;
              o_oerr    <= (best_time < last_time);
              o_drop    <= 1'b0;
              o_blk     <= 1'b0;
              o_bq      <= '0;
              o_done    <= 1'b0;
              o_last    <= 1'b0;
              last_time <= best_time;
              found     <= 1'b0;
              scan_q    <= '0;
              state     <= S_RD;
            end else begin
              o_kind <= KIND_STATUS;
              o_src  <= '0;
              o_time <= '0;
              o_data <= '0;
              o_oerr <= 1'b0;
              o_drop <= dropped;
              o_blk  <= blocked;
              o_bq   <= 2'(blocker);
              o_done <= stat.all_done;
              o_last <= 1'b1;
              state  <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign item_out.valid         = out_valid;
  assign item_out.kind          = o_kind;
  assign item_out.source_queue  = o_src;
  assign item_out.item_time     = o_time;
  assign item_out.item_data     = o_data;
  assign item_out.order_error   = o_oerr;
  assign item_out.input_dropped = o_drop;
  assign item_out.blocked       = o_blk;
  assign item_out.blocker_queue = o_bq;
  assign item_out.all_done      = o_done;
  assign item_out.last          = o_last;

endmodule

// File: test/tb_timestamp_ordered_multi_queue_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timestamp_ordered_multi_queue_merge
// Self-checking bench for the time-ordered queue merge. A behavioral merge
// model predicts every dispatched item word and closing status word; a
// monitor compares each accepted output word against the oldest prediction.
// Directed cases cover ties, full/retired/unknown queues, late items, flush
// and an empty mask. Random traffic follows with varied masks, random
// source/sink idling and one long output stall.
// ----------------------------------------------------------------------------
module tb_timestamp_ordered_multi_queue_merge;
  import tomqm_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no handshake on either side
  localparam int HOLD_CYCLES    = 400;   // long sink stall for the backpressure case
  localparam int SETTLE_CYCLES  = 4;     // block is idle once the status word is taken

  // one output word as the monitor sees it
  typedef struct packed {
    logic                 kind;
    logic [QW-1:0]        src;
    logic [TIME_BITS-1:0] stamp;
    logic [DATA_BITS-1:0] data;
    logic                 oerr;
    logic                 dropped;
    logic                 blk;
    logic [QW-1:0]        bq;
    logic                 done;
    logic                 last;
  } word_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [3:0] cfg_wdata;

  tomqm_in_if  item_in_if ();
  tomqm_out_if item_out_if ();

  timestamp_ordered_multi_queue_merge dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .item_in  (item_in_if),
    .item_out (item_out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Merge model state
  // --------------------------------------------------------------------------
  logic [TIME_BITS-1:0]  q_time     [NUM_QUEUES][FIFO_DEPTH];
  logic [DATA_BITS-1:0]  q_data     [NUM_QUEUES][FIFO_DEPTH];
  logic [PW-1:0]         q_head     [NUM_QUEUES];
  logic [PW:0]           q_fill     [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] q_finished;
  logic [NUM_QUEUES-1:0] q_retired;
  logic [NUM_QUEUES-1:0] q_mask;
  logic [TIME_BITS-1:0]  q_last_time;
  logic [QW-1:0]         q_blocker;

  word_t pending_words[$];   // predicted words not yet seen at the output

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int hold_seq      = 0;     // bumped by a test to request a long sink stall
  int hold_seen     = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int bad_words     = 0;
  int useful_items  = 0;     // accepted words the block did not just drop
  logic word_dropped;
  logic [TIME_BITS-1:0] stamp_clock;  // running time base for well-ordered pushes

  // Mask write: every slot whose bit flips starts over empty and open.
  function automatic void apply_mask(input logic [NUM_QUEUES-1:0] v);
    logic [NUM_QUEUES-1:0] flipped;
    flipped = v ^ q_mask;
    for (int q = 0; q < NUM_QUEUES; q++) begin
      if (flipped[q]) begin
        q_head[q]     = '0;
        q_fill[q]     = '0;
        q_finished[q] = 1'b0;
        q_retired[q]  = 1'b0;
      end
    end
    q_mask = v;
  endfunction

  // Append one predicted word behind the ones already waiting.
  function automatic void queue_word(input word_t w);
    pending_words.insert(pending_words.size(), w);
  endfunction

  // Apply one input word, then queue the dispatched items and the status word.
  // Returns 1 when a push was thrown away.
  function automatic logic merge_predict(input op_t op, input logic [QW-1:0] qid,
                                         input logic [TIME_BITS-1:0] ts,
                                         input logic [DATA_BITS-1:0] pl);
    logic                 dropped;
    logic                 stalled;
    logic                 found;
    logic                 stop;
    logic [QW-1:0]        best;
    logic [TIME_BITS-1:0] best_t;
    logic [PW-1:0]        pos;
    logic [NUM_QUEUES-1:0] live;
    word_t                w;
    dropped = 1'b0;
    stalled = 1'b0;
    stop    = 1'b0;
    live    = q_mask & ~q_retired;
    case (op)
      OP_PUSH: begin
        if (live[qid] && !q_finished[qid] && q_fill[qid] < FIFO_DEPTH) begin
          pos = q_head[qid] + q_fill[qid][PW-1:0];
          q_time[qid][pos] = ts;
          q_data[qid][pos] = pl;
          q_fill[qid] = q_fill[qid] + 1'b1;
        end else begin
          dropped = 1'b1;
        end
      end
      OP_FINISH: begin
        if (live[qid]) q_finished[qid] = 1'b1;
      end
      OP_FLUSH: begin
        q_finished = q_finished | live;
      end
      default: begin
      end
    endcase

    // Each pass scans in index order; an empty open queue stops the merge,
    // an empty finished one is retired and skipped.
    for (int g = 0; g < NUM_QUEUES * FIFO_DEPTH && !stop; g++) begin
      found  = 1'b0;
      best   = '0;
      best_t = '0;
      for (int q = 0; q < NUM_QUEUES; q++) begin
        if (!stalled && q_mask[q] && !q_retired[q]) begin
          if (q_fill[q] == 0) begin
            if (q_finished[q]) begin
              q_retired[q] = 1'b1;
            end else begin
              q_blocker = QW'(q);
              stalled   = 1'b1;
            end
          end else if (!found || q_time[q][q_head[q]] < best_t) begin
            // strict compare keeps the lowest index on equal times
            found  = 1'b1;
            best   = QW'(q);
            best_t = q_time[q][q_head[q]];
          end
        end
      end
      if (stalled || !found) begin
        stop = 1'b1;
      end else begin
        w       = '0;
        w.kind  = KIND_ITEM;
        w.src   = best;
        w.stamp = best_t;
        w.data  = q_data[best][q_head[best]];
        w.oerr  = (best_t < q_last_time);
        queue_word(w);
        q_last_time  = best_t;
        q_head[best] = q_head[best] + 1'b1;
        q_fill[best] = q_fill[best] - 1'b1;
      end
    end

    w         = '0;
    w.kind    = KIND_STATUS;
    w.dropped = dropped;
    w.blk     = stalled;
    w.bq      = q_blocker;
    w.done    = ((q_mask & ~q_retired) == '0);
    w.last    = 1'b1;
    queue_word(w);
    return dropped;
  endfunction

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------
  // valid stays high after acceptance; the next call (or wait_idle) may lower it,
  // so back-to-back words never see valid dropped and raised in one step.
  task automatic send_word(input op_t op, input logic [QW-1:0] qid,
                           input logic [TIME_BITS-1:0] ts,
                           input logic [DATA_BITS-1:0] pl);
    while ($urandom_range(99) < src_idle_pct) begin
      item_in_if.valid <= 1'b0;
      @(posedge clk);
    end
    item_in_if.valid     <= 1'b1;
    item_in_if.operation <= op;
    item_in_if.queue_id  <= qid;
    item_in_if.timestamp <= ts;
    item_in_if.payload   <= pl;
    @(posedge clk);
    while (!item_in_if.ready) @(posedge clk);
    word_dropped = merge_predict(op, qid, ts, pl);
    if (!word_dropped) useful_items++;
  endtask

  // Block is idle once every predicted word is out; SETTLE_CYCLES adds margin.
  task automatic wait_idle();
    item_in_if.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mask(input logic [NUM_QUEUES-1:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    apply_mask(v);
    cfg_we <= 1'b0;
  endtask

  // Mostly in-order pushes to open queues, with a sprinkle of late items,
  // noise, finishes, flushes and no-ops. Stops once every queue is closed.
  task automatic run_chunk(input int want);
    int   start;
    int   tries;
    int   roll;
    int   qq;
    logic [63:0] rnd;
    start       = useful_items;
    tries       = 0;
    stamp_clock = TIME_BITS'({$urandom(), $urandom()}) & 48'hFFFF_FFF0_0000;
    while (useful_items - start < want && tries < 3 * want &&
           (q_mask & ~q_retired & ~q_finished) != '0) begin
      tries++;
      roll = $urandom_range(99);
      if (roll < 76) begin
        do qq = $urandom_range(NUM_QUEUES - 1);
        while (!(q_mask[qq] && !q_retired[qq] && !q_finished[qq]));
        // zero step -> equal times
        stamp_clock = stamp_clock + TIME_BITS'($urandom_range(24));
        send_word(OP_PUSH, QW'(qq), stamp_clock, $urandom());
      end else if (roll < 82) begin
        // late item: older than what was already released
        send_word(OP_PUSH, QW'($urandom_range(NUM_QUEUES - 1)),
                  stamp_clock - TIME_BITS'($urandom_range(4000, 1)), $urandom());
      end else if (roll < 87) begin
        rnd = {$urandom(), $urandom()};
        send_word(op_t'($urandom_range(3)), QW'($urandom_range(NUM_QUEUES - 1)),
                  rnd[TIME_BITS-1:0], $urandom());
      end else if (roll < 90) begin
        send_word(OP_FINISH, QW'($urandom_range(NUM_QUEUES - 1)), '0, '0);
      end else if (roll < 92) begin
        send_word(OP_FLUSH, '0, '0, '0);
      end else if (roll < 95) begin
        send_word(OP_NOP, QW'($urandom_range(NUM_QUEUES - 1)), '0, '0);
      end else begin
        // any slot, possibly unregistered or closed
        stamp_clock = stamp_clock + TIME_BITS'($urandom_range(24));
        send_word(OP_PUSH, QW'($urandom_range(NUM_QUEUES - 1)), stamp_clock,
                  $urandom());
      end
    end
    if ($urandom_range(1) == 1) send_word(OP_FLUSH, '0, '0, '0);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed_merge();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    write_mask(4'hF);
    send_word(OP_PUSH, 2'd0, 48'd5, 32'h0000_000A);            // blocks on q1
    send_word(OP_PUSH, 2'd1, 48'd5, 32'h0000_000B);
    send_word(OP_PUSH, 2'd2, 48'd3, 32'h0000_000C);
    send_word(OP_PUSH, 2'd3, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF); // time/data extremes
    send_word(OP_PUSH, 2'd2, 48'd5, 32'h0000_000D);            // three-way tie at 5
    send_word(OP_NOP, 2'd3, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < FIFO_DEPTH; i++)                        // q1 fills, last one dropped
      send_word(OP_PUSH, 2'd1, 48'd10 + TIME_BITS'(i), 32'h1000_0000 + i);
    send_word(OP_FINISH, 2'd0, '0, '0);                         // empty -> retired
    send_word(OP_FINISH, 2'd0, '0, '0);                         // retired: ignored
    send_word(OP_PUSH, 2'd0, 48'd40, 32'h0000_0001);            // retired: dropped
    send_word(OP_PUSH, 2'd2, 48'd0, 32'h0000_0000);             // late item
    send_word(OP_FINISH, 2'd2, '0, '0);
    send_word(OP_FINISH, 2'd2, '0, '0);                         // second finish
    send_word(OP_FLUSH, '0, '0, '0);                            // drain all, all done
    send_word(OP_PUSH, 2'd3, 48'd50, 32'h5555_5555);            // after done: dropped
  endtask

  task automatic test_mask_edges();
    write_mask(4'h0);                                           // nothing registered
    send_word(OP_PUSH, 2'd1, 48'd7, 32'hAAAA_AAAA);
    send_word(OP_FINISH, 2'd2, '0, '0);
    send_word(OP_FLUSH, '0, '0, '0);
    write_mask(4'b0101);
    send_word(OP_PUSH, 2'd1, 48'd9, 32'h1234_5678);             // unregistered slot
    send_word(OP_FINISH, 2'd3, '0, '0);                         // unknown queue
    send_word(OP_PUSH, 2'd2, 48'd9, 32'h8765_4321);
  endtask

  task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n);
    int goal;
    int pick;
    logic [NUM_QUEUES-1:0] next_mask;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    goal          = useful_items + n;
    while (useful_items < goal) begin
      pick = $urandom_range(5);
      case (pick)
        0:       next_mask = 4'hF;
        1:       next_mask = 4'h1;
        2:       next_mask = 4'h8;
        default: next_mask = NUM_QUEUES'($urandom_range(15, 1));
      endcase
      // all closed (or at random): toggle through zero so every slot reopens fresh
      if ((q_mask & ~q_retired & ~q_finished) == '0 || $urandom_range(2) == 0)
        write_mask(4'h0);
      write_mask(next_mask);
      run_chunk(35);
    end
  endtask

  // Sink holds off for a long stretch while the source keeps offering words.
  task automatic test_backpressure();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    write_mask(4'h0);
    write_mask(4'hF);
    hold_seq++;
    run_chunk(30);
  endtask

  // --------------------------------------------------------------------------
  // Sink ready: random idling, overridden by a requested long stall
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      item_out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      item_out_if.ready <= 1'b0;
    end else begin
      item_out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor: compare each accepted word against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    word_t got;
    word_t want;
    if (!rst && item_out_if.valid && item_out_if.ready) begin
      got.kind    = item_out_if.kind;
      got.src     = item_out_if.source_queue;
      got.stamp   = item_out_if.item_time;
      got.data    = item_out_if.item_data;
      got.oerr    = item_out_if.order_error;
      got.dropped = item_out_if.input_dropped;
      got.blk     = item_out_if.blocked;
      got.bq      = item_out_if.blocker_queue;
      got.done    = item_out_if.all_done;
      got.last    = item_out_if.last;
      if (pending_words.size() == 0) begin
        bad_words++;
        if (bad_words <= 10)
          $display("%0t unexpected word: kind=%0d src=%0d time=%h data=%h last=%0d",
                   $realtime, got.kind, got.src, got.stamp, got.data, got.last);
      end else begin
        want = pending_words.pop_front();
        if (got.kind !== want.kind || got.src !== want.src || got.stamp !== want.stamp ||
            got.data !== want.data || got.oerr !== want.oerr ||
            got.dropped !== want.dropped || got.blk !== want.blk ||
            got.bq !== want.bq || got.done !== want.done || got.last !== want.last) begin
          bad_words++;
          if (bad_words <= 10) begin
            $display("%0t mismatch exp: kind=%0d src=%0d time=%h data=%h oerr=%0d drop=%0d blk=%0d bq=%0d done=%0d last=%0d",
                     $realtime, want.kind, want.src, want.stamp, want.data, want.oerr,
                     want.dropped, want.blk, want.bq, want.done, want.last);
            $display("%0t mismatch got: kind=%0d src=%0d time=%h data=%h oerr=%0d drop=%0d blk=%0d bq=%0d done=%0d last=%0d",
                     $realtime, got.kind, got.src, got.stamp, got.data, got.oerr,
                     got.dropped, got.blk, got.bq, got.done, got.last);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: cycles since the last handshake on either channel
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (item_in_if.valid && item_in_if.ready) ||
        (item_out_if.valid && item_out_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    do @(posedge clk); while (quiet_cycles < WATCHDOG_LIMIT);
    $display("timestamp_ordered_multi_queue_merge regression: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_wdata            <= '0;
    item_in_if.valid     <= 1'b0;
    item_in_if.operation <= OP_NOP;
    item_in_if.queue_id  <= '0;
    item_in_if.timestamp <= '0;
    item_in_if.payload   <= '0;
    // model reset state; store contents are never read before written
    for (int q = 0; q < NUM_QUEUES; q++) begin
      q_head[q] = '0;
      q_fill[q] = '0;
    end
    q_finished  = '0;
    q_retired   = '0;
    q_mask      = '0;
    q_last_time = '0;
    q_blocker   = '0;
    stamp_clock = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_merge();
    test_mask_edges();
    test_random_traffic(33, 61, 110);
    test_random_traffic(61, 33, 110);
    test_backpressure();
    test_random_traffic(0, 0, 70);

    wait_idle();
    repeat (16) @(posedge clk);
    if (bad_words == 0 && pending_words.size() == 0)
      $display("timestamp_ordered_multi_queue_merge regression: pass");
    else
      $display("timestamp_ordered_multi_queue_merge regression: fail");
    $finish;
  end

endmodule
